// File: rtl/core/sm3_pkg.sv
// Shared types, constants and round functions of the SM3 hash engine.
package sm3_pkg;

   localparam logic [31:0] T_LOW  = 32'h79CC4519;
   localparam logic [31:0] T_HIGH = 32'h7A879D8A;
   localparam logic [31:0] PAD_MARK = 32'h80000000;
   localparam int unsigned QDEPTH = 4;
   localparam int unsigned QAW = $clog2(QDEPTH);

   localparam logic [2:0] CSR_USE_STD = 3'd0;
   localparam logic [2:0] CSR_IV01    = 3'd1;
   localparam logic [2:0] CSR_IV23    = 3'd2;
   localparam logic [2:0] CSR_IV45    = 3'd3;
   localparam logic [2:0] CSR_IV67    = 3'd4;
   localparam logic [2:0] CSR_PRIOR   = 3'd5;

   localparam logic [255:0] STD_IV = {
      32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
      32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E};

   typedef struct packed {
      logic [31:0] msg_word;
      logic [2:0]  word_bytes;
      logic        last_word;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  digest_index;
      logic        digest_last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] word;
      logic        first;
      logic        last;
   } qentry_type;

   typedef struct packed {
      logic         use_std;
      logic [255:0] iv;
   } ivcfg_type;

   function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] d;
      d = {x, x} << n;
      return d[63:32];
   endfunction

   function automatic logic [31:0] p0(input logic [31:0] x);
      return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
   endfunction

   function automatic logic [31:0] p1(input logic [31:0] x);
      return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
   endfunction

   function automatic logic [31:0] tconst(input logic [5:0] j);
      logic [31:0] base;
      base = (j < 6'd16) ? T_LOW : T_HIGH;
      return rotl(base, j[4:0]);
   endfunction

endpackage

// File: rtl/core/sm3_front.sv
// Front end: takes message words, keeps the byte count and generates padding.
module sm3_front import sm3_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_start,
   input  req_type     req_data,
   output logic        req_busy,
   input  logic [60:0] prior_length,
   input  logic        q_full,
   output logic        q_push,
   output qentry_type  q_entry,
   input  logic        digest_done
);

   localparam logic [2:0] P_NONE = 3'd0;
   localparam logic [2:0] P_MARK = 3'd1;
   localparam logic [2:0] P_ZERO = 3'd2;
   localparam logic [2:0] P_LHI  = 3'd3;
   localparam logic [2:0] P_LLO  = 3'd4;

   logic [2:0]  pad_ff, pad_in;
   logic        open_ff, open_in;
   logic        wait_ff, wait_in;
   logic [3:0]  pos_ff, pos_in;
   logic [60:0] count_ff, count_in;
   logic        accept;
   logic [60:0] base;
   logic [2:0]  nb;
   logic [31:0] merged;
   logic [63:0] bits;

   assign req_busy = wait_ff || q_full;
   assign accept   = req_start && !req_busy;
   assign base     = open_ff ? count_ff : prior_length;
   assign nb       = (req_data.word_bytes > 3'd4) ? 3'd4 : req_data.word_bytes;
   assign bits     = {count_ff, 3'b000};

   always_comb begin
      case (nb)
         3'd0:    merged = PAD_MARK;
         3'd1:    merged = {req_data.msg_word[31:24], 24'h800000};
         3'd2:    merged = {req_data.msg_word[31:16], 16'h8000};
         3'd3:    merged = {req_data.msg_word[31:8], 8'h80};
         default: merged = req_data.msg_word;
      endcase
   end

   always_comb begin
      pad_in   = pad_ff;
      open_in  = open_ff;
      wait_in  = wait_ff;
      count_in = count_ff;
      q_push   = 1'b0;
      q_entry  = '{word: req_data.msg_word, first: !open_ff, last: 1'b0};
      if (accept) begin
         q_push  = 1'b1;
         open_in = !req_data.last_word;
         if (req_data.last_word) begin
            count_in = base + {58'd0, nb};
            q_entry.word = merged;
            wait_in = 1'b1;
            pad_in  = (nb == 3'd4) ? P_MARK : P_ZERO;
         end else begin
            count_in = base + 61'd4;
         end
      end else if (!q_full) begin
         q_entry.first = 1'b0;
         case (pad_ff)
            P_MARK: begin
               q_push = 1'b1;
               q_entry.word = PAD_MARK;
               pad_in = P_ZERO;
            end
            P_ZERO: begin
               q_push = 1'b1;
               if (pos_ff == 4'd14) begin
                  q_entry.word = bits[63:32];
                  pad_in = P_LLO;
               end else begin
                  q_entry.word = '0;
               end
            end
            P_LHI: begin
               q_push = 1'b1;
               q_entry.word = bits[63:32];
               pad_in = P_LLO;
            end
            P_LLO: begin
               q_push = 1'b1;
               q_entry.word = bits[31:0];
               q_entry.last = 1'b1;
               pad_in = P_NONE;
            end
            default: pad_in = P_NONE;
         endcase
      end
      if (digest_done) wait_in = 1'b0;
      pos_in = q_push ? pos_ff + 4'd1 : pos_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_ff   <= P_NONE;
         open_ff  <= 1'b0;
         wait_ff  <= 1'b0;
         pos_ff   <= '0;
         count_ff <= '0;
      end else begin
         pad_ff   <= pad_in;
         open_ff  <= open_in;
         wait_ff  <= wait_in;
         pos_ff   <= pos_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: rtl/core/sm3_queue.sv
// Short word queue between the front end and the compression core.
module sm3_queue import sm3_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  qentry_type push_entry,
   input  logic       pop,
   output qentry_type head,
   output logic       empty,
   output logic       full
);

   qentry_type     mem_ff [QDEPTH];
   logic [QAW-1:0] wptr_ff, rptr_ff;
   logic [QAW:0]   cnt_ff;

   assign empty = (cnt_ff == '0);
   assign full  = (cnt_ff == (QAW+1)'(QDEPTH));
   assign head  = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         if (push) wptr_ff <= wptr_ff + 1'b1;
         if (pop)  rptr_ff <= rptr_ff + 1'b1;
         cnt_ff <= cnt_ff + {{QAW{1'b0}}, push} - {{QAW{1'b0}}, pop};
      end
   end

endmodule

// File: rtl/core/sm3_back.sv
// Compression core: block window, 64 rounds one per cycle, digest output.
module sm3_back import sm3_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  ivcfg_type  ivcfg,
   input  logic       q_empty,
   input  qentry_type q_head,
   output logic       q_pop,
   output logic       rsp_valid,
   output rsp_type    rsp_data,
   output logic       digest_done
);

   localparam logic [1:0] S_FILL  = 2'd0;
   localparam logic [1:0] S_ROUND = 2'd1;
   localparam logic [1:0] S_XOR   = 2'd2;
   localparam logic [1:0] S_OUT   = 2'd3;

   logic [1:0]  state_ff;
   logic [3:0]  fill_ff;
   logic [5:0]  rnd_ff;
   logic [2:0]  idx_ff;
   logic        final_ff;
   logic [31:0] w_ff [16];
   logic [31:0] cv_ff [8];
   logic [31:0] r_ff [8];
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   logic        done_ff;

   logic [31:0] a12, ss1, ss2, ffv, ggv, tt1, tt2, wnew;
   logic        early;

   assign q_pop       = (state_ff == S_FILL) && !q_empty;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_ff;
   assign digest_done = done_ff;

   assign early = (rnd_ff < 6'd16);
   assign a12 = rotl(r_ff[0], 5'd12);
   assign ss1 = rotl(a12 + r_ff[4] + tconst(rnd_ff), 5'd7);
   assign ss2 = ss1 ^ a12;
   assign ffv = early ? (r_ff[0] ^ r_ff[1] ^ r_ff[2])
                      : ((r_ff[0] & r_ff[1]) | (r_ff[0] & r_ff[2]) | (r_ff[1] & r_ff[2]));
   assign ggv = early ? (r_ff[4] ^ r_ff[5] ^ r_ff[6])
                      : ((r_ff[4] & r_ff[5]) | (~r_ff[4] & r_ff[6]));
   assign tt1 = ffv + r_ff[3] + ss2 + (w_ff[0] ^ w_ff[4]);
   assign tt2 = ggv + r_ff[7] + ss1 + w_ff[0];
   assign wnew = p1(w_ff[0] ^ w_ff[7] ^ rotl(w_ff[13], 5'd15))
               ^ rotl(w_ff[3], 5'd7) ^ w_ff[10];

   // message window: shifts in on fill and on every round
   always_ff @(posedge clock) begin
      if (q_pop || state_ff == S_ROUND) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= q_pop ? q_head.word : wnew;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 8; k++) cv_ff[k] <= STD_IV[255-32*k -: 32];
      end else if (q_pop && q_head.first) begin
         for (int k = 0; k < 8; k++)
            cv_ff[k] <= ivcfg.use_std ? STD_IV[255-32*k -: 32] : ivcfg.iv[255-32*k -: 32];
      end else if (state_ff == S_XOR) begin
         for (int k = 0; k < 8; k++) cv_ff[k] <= cv_ff[k] ^ r_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_FILL) begin
         for (int k = 0; k < 8; k++) r_ff[k] <= cv_ff[k];
      end else if (state_ff == S_ROUND) begin
         r_ff[0] <= tt1;
         r_ff[1] <= r_ff[0];
         r_ff[2] <= rotl(r_ff[1], 5'd9);
         r_ff[3] <= r_ff[2];
         r_ff[4] <= p0(tt2);
         r_ff[5] <= r_ff[4];
         r_ff[6] <= rotl(r_ff[5], 5'd19);
         r_ff[7] <= r_ff[6];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= '{digest_word: cv_ff[idx_ff], digest_index: idx_ff,
                  digest_last: (idx_ff == 3'd7)};
      if (q_pop) final_ff <= q_head.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_FILL;
         fill_ff      <= '0;
         rnd_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         done_ff      <= 1'b0;
         case (state_ff)
            S_FILL: begin
               if (q_pop) begin
                  fill_ff <= fill_ff + 4'd1;
                  if (fill_ff == 4'd15) state_ff <= S_ROUND;
               end
               rnd_ff <= '0;
            end
            S_ROUND: begin
               rnd_ff <= rnd_ff + 6'd1;
               if (rnd_ff == 6'd63) state_ff <= S_XOR;
            end
            S_XOR: begin
               idx_ff   <= '0;
               state_ff <= final_ff ? S_OUT : S_FILL;
            end
            S_OUT: begin
               rsp_valid_ff <= 1'b1;
               idx_ff <= idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  done_ff  <= 1'b1;
                  state_ff <= S_FILL;
               end
            end
            default: state_ff <= S_FILL;
         endcase
      end
   end

endmodule

// File: rtl/core/sm3_hash_engine_top.sv
// Top level of the SM3 hash engine: registers, front end, queue and core.
//
//  channel  ports                          direction  transaction
//  req      req_start/req_busy/req_data    in         start && !busy
//  rsp      rsp_valid/rsp_data             out        rsp_valid, one cycle
//  csr      csr_we/csr_index/csr_wdata     in         csr_we
//
// A 16-word block is filled from the queue, then runs 64 rounds in the
// one-round-per-cycle core and one update; no new words are popped meanwhile.
// The last word adds one or two padded blocks, then eight digest words; busy
// stays high from the last word until the last digest word has gone out.
// Synchronous reset restores the standard IV and register defaults; results
// cannot be stalled.
module sm3_hash_engine_top import sm3_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_start,
   output logic        req_busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   logic        use_std_ff;
   logic [63:0] iv_ff [4];
   logic [60:0] prior_ff;
   ivcfg_type   ivcfg;
   logic        q_push, q_pop, q_empty, q_full, done;
   qentry_type  q_entry, q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         use_std_ff <= 1'b1;
         for (int i = 0; i < 4; i++) iv_ff[i] <= '0;
         prior_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_USE_STD: use_std_ff <= csr_wdata[0];
            CSR_IV01:    iv_ff[0] <= csr_wdata;
            CSR_IV23:    iv_ff[1] <= csr_wdata;
            CSR_IV45:    iv_ff[2] <= csr_wdata;
            CSR_IV67:    iv_ff[3] <= csr_wdata;
            CSR_PRIOR:   prior_ff <= csr_wdata[60:0];
            default:     ;
         endcase
      end
   end

   assign ivcfg = '{use_std: use_std_ff, iv: {iv_ff[0], iv_ff[1], iv_ff[2], iv_ff[3]}};

   sm3_front u_front (
      .clock(clock), .reset(reset),
      .req_start(req_start), .req_data(req_data), .req_busy(req_busy),
      .prior_length(prior_ff),
      .q_full(q_full), .q_push(q_push), .q_entry(q_entry),
      .digest_done(done)
   );

   sm3_queue u_queue (
      .clock(clock), .reset(reset),
      .push(q_push), .push_entry(q_entry),
      .pop(q_pop), .head(q_head), .empty(q_empty), .full(q_full)
   );

   sm3_back u_back (
      .clock(clock), .reset(reset), .ivcfg(ivcfg),
      .q_empty(q_empty), .q_head(q_head), .q_pop(q_pop),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .digest_done(done)
   );

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.digest_last |-> rsp_data.digest_index == 3'd7)
      else $error("digest_last off the eighth word");

   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      req_start && !req_busy && req_data.last_word |=> req_busy)
      else $error("new word accepted while digest pending");

   a_index_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.digest_last |=>
         rsp_valid && rsp_data.digest_index == $past(rsp_data.digest_index) + 3'd1)
      else $error("digest words not back to back");

endmodule
